// ===== design/ubsp_pkg.sv =====
// Shared constants, control word type and microprogram builder for the B-spline evaluator.
package ubsp_pkg;

    localparam int COORD_W        = 16;
    localparam int CFG_W          = 3;
    localparam int DEGREE_DEFAULT = 2;
    localparam int MAX_DEGREE     = 3;
    localparam int MAX_LOG2       = 5;
    localparam int SLOG2_RESET    = 3;
    localparam int FRAC_W         = 16;
    localparam int WEIGHT_W       = FRAC_W + 1;
    // Sample index runs 0 .. 2^MAX_LOG2 inclusive.
    localparam int SPAN_W         = MAX_LOG2 + 1;
    // Weight numerator on a 2^MAX_LOG2 grid, up to MAX_DEGREE * 2^MAX_LOG2.
    localparam int NUM_W          = MAX_LOG2 + 2;
    localparam int NUMSH_W        = NUM_W + FRAC_W - MAX_LOG2;
    // ceil(2^20 / 3): exact floor(z / 3) for z below 2^18.
    localparam int RECIP3_SH      = 20;
    localparam int RECIP3_W       = 19;
    localparam int RECIP3         = 349526;

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_WGT  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_WB   = 3'd3;
    localparam logic [2:0] OP_ROT  = 3'd4;
    localparam logic [2:0] OP_EMIT = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] coef;   // integer part of the weight numerator, in spans
        logic [1:0] den;    // lerp level divisor, 1 .. 3
    } ucode_t;

    // Control word at a given step of the program for one curve sample.
    // Every level runs a lerp at each of the degree queue positions (the
    // extra ones produce values that are never used), then rotates once so
    // that the level's results line up at the queue head.
    function automatic ucode_t ucode_word(input int step, input int degree);
        ucode_t w;
        int     n;
        w.op   = OP_EMIT;
        w.coef = 2'd0;
        w.den  = 2'd1;
        if (step == 0) begin
            w.op = OP_LOAD;
        end
        n = 1;
        for (int r = 1; r <= MAX_DEGREE; r++) begin
            if (r <= degree) begin
                for (int i = 1; i <= MAX_DEGREE; i++) begin
                    if (i <= degree) begin
                        if (step == n) begin
                            w.op   = OP_WGT;
                            w.coef = (i <= degree - r + 1) ? 2'(degree - r - i + 1) : 2'd0;
                            w.den  = 2'(degree - r + 1);
                        end
                        if (step == n + 1) begin
                            w.op = OP_MUL;
                        end
                        if (step == n + 2) begin
                            w.op = OP_WB;
                        end
                        n = n + 3;
                    end
                end
                if (step == n) begin
                    w.op = OP_ROT;
                end
                n = n + 1;
            end
        end
        return w;
    endfunction

endpackage

// ===== design/uniform_bspline_de_boor.sv =====
// Uniform B-spline curve evaluator (de Boor) with a microcoded lerp datapath.
// Each sample is worked through the microprogram on the one shared lerp unit, and an emit waits
// while the output register holds a sample not yet taken; a new request is taken only once the
// previous run is through. A span request takes 2^L samples (one more if last).
// A request that does not fill the window completes with no result.
// Reset (aresetn, synchronous, active low) clears the window count and returns samples_log2 to 3.
module uniform_bspline_de_boor #(
    parameter int DEGREE = ubsp_pkg::DEGREE_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write channel: samples_log2.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ubsp_pkg::CFG_W-1:0]           cfg_samples_log2,
    // Control point requests.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ubsp_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [ubsp_pkg::COORD_W-1:0]  s_point_y,
    input  logic                                 s_last_point,
    // Curve samples.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ubsp_pkg::COORD_W-1:0]  m_curve_x,
    output logic signed [ubsp_pkg::COORD_W-1:0]  m_curve_y,
    output logic                                 m_last_of_run
);
    import ubsp_pkg::*;

    // One sample: load, DEGREE levels of (DEGREE lerps of three steps, one rotate), emit.
    localparam int PROG_LEN  = 2 + DEGREE * (3 * DEGREE + 1);
    localparam int STEP_W    = $clog2(PROG_LEN);
    localparam int ROM_DEPTH = 2 ** STEP_W;
    localparam int PS_W      = $clog2(DEGREE + 1);
    localparam int PROD_W    = 2 * WEIGHT_W + 1;
    localparam int ACC_W     = PROD_W + 1;

    // ------------------------------------------------------------------
    // Microprogram ROM, built at elaboration from the degree.
    // ------------------------------------------------------------------
    ucode_t ucode_rom [ROM_DEPTH];

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        assign ucode_rom[g] = ucode_word(g, DEGREE);
    end

    // ------------------------------------------------------------------
    // State.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]          slog2_reg;
    logic [PS_W-1:0]           points_seen_reg, points_seen_next;
    logic                      busy_reg, busy_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [SPAN_W-1:0]         s_reg, s_next;
    logic [2:0]                lg_reg;
    logic                      last_reg;

    // Window of control points, oldest at index 0.
    logic signed [COORD_W-1:0] win_x_reg [DEGREE+1];
    logic signed [COORD_W-1:0] win_y_reg [DEGREE+1];
    // Working queue of the lerp triangle; the unit always reads the head pair.
    logic signed [COORD_W-1:0] p_x_reg [DEGREE+1];
    logic signed [COORD_W-1:0] p_y_reg [DEGREE+1];

    logic [WEIGHT_W-1:0]       w_reg;
    logic signed [PROD_W-1:0]  prod_x_reg, prod_y_reg;
    logic signed [COORD_W-1:0] a_x_reg, a_y_reg;

    logic                      m_valid_reg;
    logic signed [COORD_W-1:0] m_curve_x_reg, m_curve_y_reg;
    logic                      m_last_reg;

    // ------------------------------------------------------------------
    // Handshakes. A new control point is taken only between runs; the
    // output register lets the last sample of a run wait while the next
    // request is already being taken.
    // ------------------------------------------------------------------
    ucode_t                    ucode;
    logic                      accept;
    logic                      out_free;
    logic                      win_full;
    logic [SPAN_W-1:0]         count;
    logic [SPAN_W-1:0]         last_s;
    logic                      emit;
    logic [2:0]                lg_start;

    assign ucode     = ucode_rom[step_reg];
    assign cfg_ready = 1'b1;
    assign s_ready   = !busy_reg;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign win_full  = (points_seen_reg == PS_W'(DEGREE));
    assign count     = SPAN_W'(1) << lg_reg;
    // A last point adds the span end sample at u = 1.
    assign last_s    = last_reg ? count : count - SPAN_W'(1);
    assign lg_start  = (slog2_reg > 3'(MAX_LOG2)) ? 3'(MAX_LOG2) : slog2_reg;

    // ------------------------------------------------------------------
    // Sequencer: the step counter advances every cycle except on an emit
    // that waits for the output register. The emit step is the only
    // conditional jump: back to the load step for the next sample, or out.
    // ------------------------------------------------------------------
    always_comb begin
        busy_next        = busy_reg;
        step_next        = step_reg;
        s_next           = s_reg;
        points_seen_next = points_seen_reg;
        emit             = 1'b0;
        if (busy_reg) begin
            case (ucode.op)
                OP_EMIT: begin
                    if (out_free) begin
                        emit = 1'b1;
                        if (s_reg == last_s) begin
                            busy_next = 1'b0;
                        end else begin
                            s_next    = s_reg + SPAN_W'(1);
                            step_next = '0;
                        end
                    end
                end
                default: begin
                    step_next = step_reg + STEP_W'(1);
                end
            endcase
        end
        if (accept) begin
            if (win_full) begin
                busy_next = 1'b1;
                step_next = '0;
                s_next    = '0;
            end else begin
                points_seen_next = points_seen_reg + PS_W'(1);
            end
            // A last point ends the curve, whether or not it produced samples.
            if (s_last_point) begin
                points_seen_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slog2_reg       <= CFG_W'(SLOG2_RESET);
            points_seen_reg <= '0;
            busy_reg        <= 1'b0;
            step_reg        <= '0;
            s_reg           <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                slog2_reg <= cfg_samples_log2;
            end
            points_seen_reg <= points_seen_next;
            busy_reg        <= busy_next;
            step_reg        <= step_next;
            s_reg           <= s_next;
        end
    end

    // Run parameters and the control point window.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int j = 0; j < DEGREE; j++) begin
                win_x_reg[j] <= win_x_reg[j+1];
                win_y_reg[j] <= win_y_reg[j+1];
            end
            win_x_reg[DEGREE] <= s_point_x;
            win_y_reg[DEGREE] <= s_point_y;
            lg_reg            <= lg_start;
            last_reg          <= s_last_point;
        end
    end

    // ------------------------------------------------------------------
    // Weight unit. The weight (u + coef) / den on Q1.16 with the span
    // position u = s / 2^L is worked on a fixed 2^5 grid, which makes it
    // independent of L: n = s * 2^(5-L) + coef * 32, and then
    // den 1: n * 2^11, den 2: n * 2^10, den 3: floor((n * 2^11 + 1) / 3),
    // which equals the round-half-up quotient. Division by three is a
    // reciprocal multiply.
    // ------------------------------------------------------------------
    logic [SPAN_W-1:0]             s_grid;
    logic [NUM_W-1:0]              num;
    logic [NUMSH_W-1:0]            num_sh;
    logic [NUMSH_W+RECIP3_W-1:0]   recip_prod;
    logic [WEIGHT_W-1:0]           w_calc;

    assign s_grid     = s_reg << (3'(MAX_LOG2) - lg_reg);
    assign num        = NUM_W'(s_grid) + {ucode.coef, MAX_LOG2'(0)};
    assign num_sh     = NUMSH_W'(num) << (FRAC_W - MAX_LOG2);
    assign recip_prod = (NUMSH_W+RECIP3_W)'(num_sh + NUMSH_W'(1))
                      * (NUMSH_W+RECIP3_W)'(RECIP3);

    always_comb begin
        case (ucode.den)
            2'd1:    w_calc = WEIGHT_W'(num_sh);
            2'd2:    w_calc = WEIGHT_W'(num_sh >> 1);
            default: w_calc = recip_prod[RECIP3_SH +: WEIGHT_W];
        endcase
    end

    // ------------------------------------------------------------------
    // Lerp unit on the queue head: a + w * (b - a), x and y side by side.
    // ------------------------------------------------------------------
    logic signed [COORD_W:0]   diff_x, diff_y;
    logic signed [PROD_W-1:0]  mul_x, mul_y;
    logic signed [COORD_W-1:0] res_x, res_y;

    assign diff_x = {p_x_reg[1][COORD_W-1], p_x_reg[1]} - {p_x_reg[0][COORD_W-1], p_x_reg[0]};
    assign diff_y = {p_y_reg[1][COORD_W-1], p_y_reg[1]} - {p_y_reg[0][COORD_W-1], p_y_reg[0]};
    assign mul_x  = PROD_W'($signed({1'b0, w_reg})) * PROD_W'(diff_x);
    assign mul_y  = PROD_W'($signed({1'b0, w_reg})) * PROD_W'(diff_y);

    // Round half up to Q12.4 (floor after adding one half) and saturate.
    function automatic logic signed [COORD_W-1:0] lerp_out(
        input logic signed [COORD_W-1:0] a,
        input logic signed [PROD_W-1:0]  prod
    );
        logic signed [ACC_W-1:0]          acc;
        logic signed [ACC_W-FRAC_W-1:0]   q;
        acc = $signed({a, FRAC_W'(0)}) + ACC_W'(prod) + ACC_W'(1 << (FRAC_W - 1));
        q   = acc[ACC_W-1:FRAC_W];
        if (q > (ACC_W-FRAC_W)'(2 ** (COORD_W - 1) - 1)) begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end else if (q < -(ACC_W-FRAC_W)'(2 ** (COORD_W - 1))) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        return q[COORD_W-1:0];
    endfunction

    assign res_x = lerp_out(a_x_reg, prod_x_reg);
    assign res_y = lerp_out(a_y_reg, prod_y_reg);

    // Datapath driven by the control word.
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            case (ucode.op)
                OP_LOAD: begin
                    for (int j = 0; j <= DEGREE; j++) begin
                        p_x_reg[j] <= win_x_reg[j];
                        p_y_reg[j] <= win_y_reg[j];
                    end
                end
                OP_WGT: begin
                    w_reg <= w_calc;
                end
                OP_MUL: begin
                    prod_x_reg <= mul_x;
                    prod_y_reg <= mul_y;
                    a_x_reg    <= p_x_reg[0];
                    a_y_reg    <= p_y_reg[0];
                end
                OP_WB: begin
                    // Consume the head and append the new value at the tail.
                    for (int j = 0; j < DEGREE; j++) begin
                        p_x_reg[j] <= p_x_reg[j+1];
                        p_y_reg[j] <= p_y_reg[j+1];
                    end
                    p_x_reg[DEGREE] <= res_x;
                    p_y_reg[DEGREE] <= res_y;
                end
                OP_ROT: begin
                    for (int j = 0; j < DEGREE; j++) begin
                        p_x_reg[j] <= p_x_reg[j+1];
                        p_y_reg[j] <= p_y_reg[j+1];
                    end
                    p_x_reg[DEGREE] <= p_x_reg[0];
                    p_y_reg[DEGREE] <= p_y_reg[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_curve_x_reg <= p_x_reg[0];
            m_curve_y_reg <= p_y_reg[0];
            m_last_reg    <= (s_reg == last_s);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_curve_x     = m_curve_x_reg;
    assign m_curve_y     = m_curve_y_reg;
    assign m_last_of_run = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_run_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && win_full) |=> (busy_reg && step_reg == '0 && s_reg == '0))
        else $error("full window did not start a run");

    a_emit_only: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(busy_reg && ucode.op == OP_EMIT))
        else $error("sample presented outside an emit step");

    a_span_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (s_reg <= count && lg_reg <= 3'(MAX_LOG2)))
        else $error("sample index beyond the span");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && ucode.op == OP_EMIT && !out_free) |=> $stable(step_reg) && busy_reg)
        else $error("sequencer moved while the output was stalled");

endmodule

// ===== dv/ubsp_sample_checker.sv =====
// Checker that predicts the curve samples of the B-spline evaluator and compares them.
module ubsp_sample_checker #(
    parameter int DEGREE = ubsp_pkg::DEGREE_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [ubsp_pkg::CFG_W-1:0]           cfg_samples_log2,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [ubsp_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [ubsp_pkg::COORD_W-1:0]  s_point_y,
    input  logic                                 s_last_point,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [ubsp_pkg::COORD_W-1:0]  m_curve_x,
    input  logic signed [ubsp_pkg::COORD_W-1:0]  m_curve_y,
    input  logic                                 m_last_of_run,
    output int                                   mismatches,
    output int                                   samples_due
);
    import ubsp_pkg::*;

    localparam longint UNIT = longint'(1) << FRAC_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } curve_sample_t;

    curve_sample_t             pending_samples[$];
    logic signed [COORD_W-1:0] ctrl_x [0:DEGREE];
    logic signed [COORD_W-1:0] ctrl_y [0:DEGREE];
    int                        points_held;
    logic [CFG_W-1:0]          span_log2;
    int                        fail_count = 0;

    assign mismatches = fail_count;

    // One lerp level: rounded half up to Q12.4, then saturated.
    function automatic logic signed [COORD_W-1:0] lerp_round(input longint a, input longint b,
                                                             input longint w);
        longint v;
        v = w * b + (UNIT - w) * a + UNIT / 2;
        v = v >>> FRAC_W;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[COORD_W-1:0];
    endfunction

    // De Boor evaluation of the current span at u = s / 2^lg.
    function automatic curve_sample_t de_boor_point(input int s, input int lg);
        longint        px [0:DEGREE];
        longint        py [0:DEGREE];
        longint        den;
        longint        num;
        longint        w;
        curve_sample_t smp;
        for (int i = 0; i <= DEGREE; i++) begin
            px[i] = ctrl_x[i];
            py[i] = ctrl_y[i];
        end
        for (int r = 1; r <= DEGREE; r++) begin
            den = longint'(DEGREE - r + 1) << lg;
            for (int i = 1; i <= DEGREE - r + 1; i++) begin
                num   = longint'(s) + (longint'(DEGREE - r - i + 1) << lg);
                w     = (num * UNIT + den / 2) / den;
                px[i-1] = lerp_round(px[i-1], px[i], w);
                py[i-1] = lerp_round(py[i-1], py[i], w);
            end
        end
        smp.x    = px[0][COORD_W-1:0];
        smp.y    = py[0][COORD_W-1:0];
        smp.last = 1'b0;
        return smp;
    endfunction

    // Shift a control point in and queue the samples of the span it closes.
    task automatic add_span_samples(input logic signed [COORD_W-1:0] px,
                                    input logic signed [COORD_W-1:0] py, input logic end_pt);
        int            lg;
        int            count;
        curve_sample_t smp;
        lg    = (span_log2 > MAX_LOG2) ? MAX_LOG2 : int'(span_log2);
        count = 1 << lg;
        for (int i = 0; i < DEGREE; i++) begin
            ctrl_x[i] = ctrl_x[i+1];
            ctrl_y[i] = ctrl_y[i+1];
        end
        ctrl_x[DEGREE] = px;
        ctrl_y[DEGREE] = py;
        if (points_held >= DEGREE) begin
            for (int s = 0; s < count; s++) begin
                smp      = de_boor_point(s, lg);
                smp.last = !end_pt && (s + 1 == count);
                pending_samples = {pending_samples, smp};
            end
            if (end_pt) begin
                smp      = de_boor_point(count, lg);
                smp.last = 1'b1;
                pending_samples = {pending_samples, smp};
            end
        end else begin
            points_held++;
        end
        if (end_pt)
            points_held = 0;
    endtask

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        curve_sample_t want;
        if (!aresetn) begin
            for (int i = 0; i <= DEGREE; i++) begin
                ctrl_x[i] = '0;
                ctrl_y[i] = '0;
            end
            points_held = 0;
            span_log2   = CFG_W'(SLOG2_RESET);
            pending_samples.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_samples.size() == 0) begin
                    $display("%0t: unexpected sample, expected none, actual x=%0d y=%0d last=%0b",
                             $time, m_curve_x, m_curve_y, m_last_of_run);
                    fail_count++;
                end else begin
                    want = pending_samples.pop_front();
                    check_field("curve_x", want.x, m_curve_x);
                    check_field("curve_y", want.y, m_curve_y);
                    check_field("last_of_run", want.last, m_last_of_run);
                end
            end
            if (cfg_valid && cfg_ready)
                span_log2 = cfg_samples_log2;
            if (s_valid && s_ready)
                add_span_samples(s_point_x, s_point_y, s_last_point);
        end
        samples_due <= pending_samples.size();
    end

endmodule

// ===== dv/tb.sv =====
// Top of the B-spline evaluator testbench: stimulus, idling control and the verdict.
module tb;
    import ubsp_pkg::*;

    // Idling modes of a phase: which side, if any, inserts random gaps.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    localparam int NUM_PHASES = 10;
    // Cycles to let pass once the last sample is out, so that a request that
    // made no sample is surely retired before the register is touched.
    localparam int SETTLE_CYCLES = 40;

    logic                      aclk             = 1'b0;
    logic                      aresetn          = 1'b0;
    logic                      cfg_valid        = 1'b0;
    logic [CFG_W-1:0]          cfg_samples_log2 = '0;
    logic                      s_valid          = 1'b0;
    logic signed [COORD_W-1:0] s_point_x        = '0;
    logic signed [COORD_W-1:0] s_point_y        = '0;
    logic                      s_last_point     = 1'b0;
    logic                      m_ready          = 1'b0;
    logic                      cfg_ready;
    logic                      s_ready;
    logic                      m_valid;
    logic signed [COORD_W-1:0] m_curve_x;
    logic signed [COORD_W-1:0] m_curve_y;
    logic                      m_last_of_run;
    int                        mismatches;
    int                        samples_due;
    // Chance in a hundred that the sender idles or the receiver stalls in a cycle.
    int                        sender_idle_pct    = 0;
    int                        receiver_stall_pct = 0;

    // Phase plan: register value, idling mode and number of requests. Values 6
    // and 7 sit above the largest sample setting and must act as 5.
    int phase_log2  [NUM_PHASES] = '{0, 1, 2, 7, 4, 5, 6, 0, 2, 3};
    int phase_mode  [NUM_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_BOTH,
                                     IDLE_NONE, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_SEND};
    int phase_items [NUM_PHASES] = '{60, 60, 60, 12, 50, 10, 10, 60, 60, 40};

    uniform_bspline_de_boor uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_samples_log2 (cfg_samples_log2),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_point_x        (s_point_x),
        .s_point_y        (s_point_y),
        .s_last_point     (s_last_point),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_curve_x        (m_curve_x),
        .m_curve_y        (m_curve_y),
        .m_last_of_run    (m_last_of_run)
    );

    // The checker sits beside the block, watches all three channels and keeps
    // the count of failures and of samples still owed.
    ubsp_sample_checker sample_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_samples_log2 (cfg_samples_log2),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_point_x        (s_point_x),
        .s_point_y        (s_point_y),
        .s_last_point     (s_last_point),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_curve_x        (m_curve_x),
        .m_curve_y        (m_curve_y),
        .m_last_of_run    (m_last_of_run),
        .mismatches       (mismatches),
        .samples_due      (samples_due)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The receiver is ready every cycle unless the phase asks it to stall, in
    // which case it holds off in the phase's share of cycles.
    always @(posedge aclk) begin
        m_ready <= (int'($urandom_range(99)) >= receiver_stall_pct);
    end

    // Coordinates lean on the extremes and on values near zero, where the
    // rounding of the lerp levels is easiest to get wrong.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return '0;
            3:       return COORD_W'($signed($urandom_range(63)) - 32);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // Presents one control point request and returns at the edge that takes it.
    // Valid is only lowered for a sender gap, so it never drops and rises in the
    // same step when requests follow back to back.
    task automatic send_point(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py, input logic end_pt);
        while (int'($urandom_range(99)) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_point_x    <= px;
        s_point_y    <= py;
        s_last_point <= end_pt;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops sending, waits until the checker owes no sample, then lets the
    // block settle. The first edge makes sure the checker has seen the most
    // recent request before its count is trusted.
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (samples_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_samples_log2(input logic [CFG_W-1:0] lg);
        drain_and_settle();
        cfg_valid        <= 1'b1;
        cfg_samples_log2 <= lg;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed curves of random length closed by a last point. About
    // one curve in ten ends before the window is full, and now and then a stray
    // last flag breaks a curve in the middle.
    task automatic send_curves(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(DEGREE_DEFAULT, 1);
            else
                len = $urandom_range(10, DEGREE_DEFAULT + 1);
            for (int k = 0; k < len; k++)
                send_point(pick_coord(), pick_coord(),
                           (k == len - 1) || ($urandom_range(19) == 0));
            sent += len;
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, at the reset setting of eight samples per span.
        // Full scale corners so the first spans swing across the whole range.
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b1);
        // A last point as the very first point of a curve, then one as the
        // second: both end the curve without any sample.
        send_point(16'sd100, -16'sd100, 1'b1);
        send_point(-16'sd1, 16'sd1, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1);
        // Tiny values around zero exercise the round-half-up on negatives, and
        // the swing back to the extremes follows right after.
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(-16'sd1, -16'sd1, 1'b0);
        send_point(16'sd1, 16'sd1, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 1'b1);
        // The sender holds back until every sample is out, then sends a curve
        // whose last point is exactly the one that fills the window.
        drain_and_settle();
        send_point(16'sd16, -16'sd16, 1'b0);
        send_point(16'sd32, -16'sd32, 1'b0);
        send_point(16'sd48, -16'sd48, 1'b1);

        // Random part: each phase rewrites the register while the block is
        // idle, then runs its requests under its own idling mode. A side that
        // idles alone does so with a chance of 73 in a hundred; when both idle,
        // each does so with a chance of 24 in a hundred.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_samples_log2(phase_log2[p][CFG_W-1:0]);
            case (phase_mode[p])
                IDLE_SEND: begin
                    sender_idle_pct    = 73;
                    receiver_stall_pct = 0;
                end
                IDLE_RECV: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 73;
                end
                IDLE_BOTH: begin
                    sender_idle_pct    = 24;
                    receiver_stall_pct = 24;
                end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            send_curves(phase_items[p]);
        end

        drain_and_settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Safety net in case the block stops answering.
    initial begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
